FILE: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int unsigned IN_VALUE_W = 64;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIG_IDX_W  = 5;
  localparam int unsigned BCD_W      = NUM_DIGITS * 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO      = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA_OFS = 8'd55;
  localparam logic [CHAR_W-1:0] ASCII_MINUS     = 8'd45;
  localparam logic [3:0]        DEC_LIMIT       = 4'd10;

  typedef enum logic {
    RADIX_DEC = 1'b0,
    RADIX_HEX = 1'b1
  } radix_e;

  typedef struct packed {
    logic signed [IN_VALUE_W-1:0] value;
    radix_e                       radix;
  } itoa_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_char;
  } itoa_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(logic [3:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0000, d};
    if (d < DEC_LIMIT) begin
      return ext + ASCII_ZERO;
    end else begin
      return ext + ASCII_ALPHA_OFS;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// Accepts a request, forms sign and magnitude, and pushes it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_front #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                  start_i,
  input  wire itoa_pkg::itoa_req_t   req_i,
  input  wire logic                  full_i,
  output logic                       busy_o,
  output logic                       push_o,
  output logic [VALUE_BITS+1:0]      entry_o
);
  import itoa_pkg::*;

  logic [VALUE_BITS-1:0] bits;
  logic                  hex;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  assign bits = req_i.value[VALUE_BITS-1:0];
  assign hex  = (req_i.radix == RADIX_HEX);
  assign neg  = !hex && bits[VALUE_BITS-1];
  assign mag  = neg ? (~bits + VALUE_BITS'(1)) : bits;

  assign busy_o  = full_i;
  assign push_o  = start_i && !full_i;
  assign entry_o = {neg, hex, mag};

endmodule

`default_nettype wire

FILE: rtl/itoa_queue.sv
// ----------------------------------------------------------------------------
// itoa_queue
// Short FIFO between the request front and the conversion back end.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_queue #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end else begin
      return p + PTR_W'(1);
    end
  endfunction

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? next_ptr(wptr_q) : wptr_q;
    rptr_d = pop_i ? next_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> !empty_o)
    else $error("queue lost a request");

endmodule

`default_nettype wire

FILE: rtl/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// Converts a magnitude to digits and emits the characters, top digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_back #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [VALUE_BITS+1:0] entry_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     char_valid_o,
  output itoa_pkg::itoa_rsp_t      char_o
);
  import itoa_pkg::*;

  localparam int unsigned MAG_W = ((VALUE_BITS + 3) / 4) * 4;
  localparam int unsigned STEPS = MAG_W / 4;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e               state_q;
  logic                 neg_q;
  logic [MAG_W-1:0]     bin_q;
  logic [BCD_W-1:0]     dig_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIG_IDX_W-1:0] idx_q;
  logic                 out_valid_q;
  itoa_rsp_t            out_q;

  logic                 e_neg;
  logic                 e_hex;
  logic [VALUE_BITS-1:0] e_mag;
  logic [DIG_IDX_W-1:0] top_idx;

  function automatic logic [BCD_W-1:0] dabble4(logic [BCD_W-1:0] bcd, logic [3:0] nib);
    logic [BCD_W-1:0] acc;
    acc = bcd;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (acc[d*4 +: 4] >= 4'd5) begin
          acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], nib[s]};
    end
    return acc;
  endfunction

  assign e_neg = entry_i[VALUE_BITS+1];
  assign e_hex = entry_i[VALUE_BITS];
  assign e_mag = entry_i[VALUE_BITS-1:0];
  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (dig_q[d*4 +: 4] != 4'd0) begin
        top_idx = DIG_IDX_W'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      bin_q       <= '0;
      dig_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            neg_q <= e_neg;
            if (e_hex) begin
              dig_q   <= BCD_W'(e_mag);
              state_q <= ST_SCAN;
            end else begin
              dig_q   <= '0;
              bin_q   <= MAG_W'(e_mag);
              cnt_q   <= CNT_W'(STEPS - 1);
              state_q <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          dig_q <= dabble4(dig_q, bin_q[MAG_W-1 -: 4]);
          bin_q <= bin_q << 4;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx_q   <= top_idx;
          state_q <= neg_q ? ST_SIGN : ST_EMIT;
        end
        ST_SIGN: begin
          out_valid_q     <= 1'b1;
          out_q.char_out  <= ASCII_MINUS;
          out_q.last_char <= 1'b0;
          state_q         <= ST_EMIT;
        end
        ST_EMIT: begin
          out_valid_q     <= 1'b1;
          out_q.char_out  <= digit_to_ascii(dig_q[idx_q*4 +: 4]);
          out_q.last_char <= (idx_q == '0);
          if (idx_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q - DIG_IDX_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign char_valid_o = out_valid_q;
  assign char_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_q.char_out == ASCII_MINUS) |-> !out_q.last_char)
    else $error("sign emitted as last character");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_q.last_char) |=> !out_valid_q)
    else $error("character after end of number");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_q.last_char) |=> out_valid_q)
    else $error("gap inside a number");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_CONV && cnt_q != '0) |=> state_q == ST_CONV)
    else $error("conversion cut short");

endmodule

`default_nettype wire

FILE: rtl/integer_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Integer to ASCII text, signed decimal or upper-case hexadecimal.
// ----------------------------------------------------------------------------
// Channel    Ports                       Direction  Handshake
// request    start_i, busy_o, req_i      in         taken when start_i && !busy_o
// character  char_valid_o, char_o        out        one-cycle strobe, no stall
//
// A request enters a two-entry queue in the cycle it is taken; busy_o is high
// only while that queue is full.
// Decimal: the entry is loaded in ST_IDLE, converted to BCD in ST_CONV and
// scanned for its top digit in ST_SCAN, then one character per cycle leaves,
// sign first, each registered before it reaches the ports. Hex skips ST_CONV.
// Decimal digits come from the 4-bit per cycle BCD converter, and characters
// leave through the one-character-per-cycle output.
// Characters of one number leave on consecutive cycles; the receiver cannot
// stall them. Reset clears the queue and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_digits #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire itoa_pkg::itoa_req_t req_i,
  output logic                     busy_o,
  output logic                     char_valid_o,
  output itoa_pkg::itoa_rsp_t      char_o
);
  import itoa_pkg::*;

  localparam int unsigned ENTRY_W = VALUE_BITS + 2;

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;

  itoa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .start_i (start_i),
    .req_i   (req_i),
    .full_i  (full),
    .busy_o  (busy_o),
    .push_o  (push),
    .entry_o (wr_entry)
  );

  itoa_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_entry),
    .pop_i   (pop),
    .data_o  (rd_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  itoa_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (rd_entry),
    .empty_i      (empty),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .char_o       (char_o)
  );

endmodule

`default_nettype wire

FILE: verif/tb_integer_to_ascii_digits.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits
// Drives signed decimal and hex conversion requests into the converter at
// random pacing. A scoreboard predicts every ASCII character and its
// last-character flag, then checks each character strobe in order.
// ----------------------------------------------------------------------------

module tb_integer_to_ascii_digits;
  import itoa_pkg::*;

  localparam int unsigned NUM_RANDOM   = 250;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned SETTLE_LIMIT = 50;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam logic [63:0] DEC_BASE     = 64'd10;
  localparam logic [63:0] HEX_BASE     = 64'd16;

  class itoa_scoreboard;
    itoa_rsp_t pending_chars[$];
    int unsigned errors = 0;

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      errors++;
    endtask

    function void note_request(itoa_req_t req);
      logic [63:0]       magnitude;
      logic [63:0]       base;
      logic [3:0]        digit;
      logic              negative;
      logic [CHAR_W-1:0] digits_lsb_first[$];
      itoa_rsp_t         want;
      negative = 1'b0;
      if (req.radix == RADIX_HEX) begin
        magnitude = req.value;
        base = HEX_BASE;
      end else begin
        negative = req.value[IN_VALUE_W-1];
        magnitude = negative ? (~req.value + 64'd1) : req.value;
        base = DEC_BASE;
      end
      do begin
        digit = 4'(magnitude % base);
        magnitude = magnitude / base;
        if (digit < DEC_LIMIT) begin
          digits_lsb_first.push_back({4'b0000, digit} + ASCII_ZERO);
        end else begin
          digits_lsb_first.push_back({4'b0000, digit} + ASCII_ALPHA_OFS);
        end
      end while (magnitude != 0 && digits_lsb_first.size() < NUM_DIGITS);
      if (negative && digits_lsb_first.size() < NUM_DIGITS) begin
        digits_lsb_first.push_back(ASCII_MINUS);
      end
      for (int k = digits_lsb_first.size() - 1; k >= 0; k--) begin
        want.char_out = digits_lsb_first[k];
        want.last_char = (k == 0);
        pending_chars.push_back(want);
      end
    endfunction

    task check_char(itoa_rsp_t got);
      itoa_rsp_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                  got.char_out, got.last_char));
        return;
      end
      want = pending_chars.pop_front();
      if (got.char_out !== want.char_out) begin
        report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                  got.char_out, want.char_out));
      end
      if (got.last_char !== want.last_char) begin
        report_mismatch($sformatf("last_char %0b, expected %0b on char 0x%02h",
                                  got.last_char, want.last_char, want.char_out));
      end
    endtask

    function int unsigned outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  itoa_req_t req_i   = '0;
  logic      busy_o;
  logic      char_valid_o;
  itoa_rsp_t char_o;

  itoa_scoreboard board = new();

  integer_to_ascii_digits dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .char_valid_o(char_valid_o),
    .char_o      (char_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && char_valid_o) begin
      board.check_char(char_o);
    end
  end

  function automatic itoa_req_t make_req(logic [63:0] value, radix_e radix);
    itoa_req_t req;
    req.value = value;
    req.radix = radix;
    return req;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] value;
    logic [63:0] power;
    int unsigned width;
    value = {$urandom, $urandom};
    case ($urandom_range(3))
      0: begin
      end
      1: begin
        width = $urandom_range(1, 63);
        value = value & ((64'd1 << width) - 64'd1);
      end
      2: begin
        power = 64'd1;
        repeat ($urandom_range(18)) power = power * DEC_BASE;
        value = power - 64'($urandom_range(1));
      end
      default: begin
        value = 64'($urandom_range(20));
      end
    endcase
    if ($urandom_range(1)) begin
      value = ~value + 64'd1;
    end
    return value;
  endfunction

  task automatic send_request(itoa_req_t req);
    start_i <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy_o);
    board.note_request(req);
  endtask

  task automatic maybe_idle(bit allow_idle);
    if (allow_idle && $urandom_range(99) < 28) begin
      start_i <= 1'b0;
      req_i <= make_req({$urandom, $urandom}, radix_e'($urandom_range(1)));
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  initial begin
    itoa_req_t   directed[$];
    int unsigned waited;
    directed.push_back(make_req(64'd0, RADIX_DEC));
    directed.push_back(make_req(64'd0, RADIX_HEX));
    directed.push_back(make_req(64'd1, RADIX_DEC));
    directed.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, RADIX_DEC));
    directed.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, RADIX_HEX));
    directed.push_back(make_req(64'h8000_0000_0000_0000, RADIX_DEC));
    directed.push_back(make_req(64'h8000_0000_0000_0000, RADIX_HEX));
    directed.push_back(make_req(64'h7FFF_FFFF_FFFF_FFFF, RADIX_DEC));
    directed.push_back(make_req(64'h7FFF_FFFF_FFFF_FFFF, RADIX_HEX));
    directed.push_back(make_req(64'd9, RADIX_DEC));
    directed.push_back(make_req(64'd10, RADIX_DEC));
    directed.push_back(make_req(-64'sd9, RADIX_DEC));
    directed.push_back(make_req(-64'sd10, RADIX_DEC));
    directed.push_back(make_req(64'd9, RADIX_HEX));
    directed.push_back(make_req(64'd10, RADIX_HEX));
    directed.push_back(make_req(64'd15, RADIX_HEX));
    directed.push_back(make_req(64'd16, RADIX_HEX));
    directed.push_back(make_req(64'hFEDC_BA98_7654_3210, RADIX_HEX));
    directed.push_back(make_req(64'h0123_4567_89AB_CDEF, RADIX_HEX));
    directed.push_back(make_req(64'd1000000000000000000, RADIX_DEC));
    directed.push_back(make_req(64'd999999999999999999, RADIX_DEC));
    directed.push_back(make_req(-64'sd1000000000000000000, RADIX_DEC));
    directed.push_back(make_req(-64'sd123456789, RADIX_HEX));
    directed.push_back(make_req(64'd12345, RADIX_DEC));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      maybe_idle(1'b1);
      send_request(directed[i]);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      maybe_idle(i < 80 || i >= 150);
      send_request(make_req(random_value(), radix_e'($urandom_range(1))));
    end
    start_i <= 1'b0;

    waited = 0;
    while (board.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_LIMIT) @(posedge clk_i);
    if (board.outstanding() != 0) begin
      board.report_mismatch($sformatf("%0d chars never arrived", board.outstanding()));
    end

    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/itoa_pkg.sv
rtl/itoa_front.sv
rtl/itoa_queue.sv
rtl/itoa_back.sv
rtl/integer_to_ascii_digits.sv
verif/tb_integer_to_ascii_digits.sv
